// ----- hdl/cste_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cste_pkg
// Shared constants, widths and saturation helper for the corotated stress
// energy tangent core.
// ============================================================================
package cste_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IN_W      = 3 * DATA_W;
    localparam int OUT_W     = 10 * DATA_W;
    localparam int MOD_W     = 31;
    localparam int FLOOR_W   = 17;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_MODULUS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAME_LAMBDA     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PANIC_FLOOR     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_DIMENSIONAL = 8'd3;

    localparam logic [MOD_W-1:0]   RESET_MU     = MOD_W'(1 << FRAC_BITS);
    localparam logic [MOD_W-1:0]   RESET_LAMBDA = MOD_W'(1 << FRAC_BITS);
    localparam logic [FLOOR_W-1:0] RESET_FLOOR  = FLOOR_W'(1);

    // divider: numerator and denominator magnitude widths, quotient bits kept
    localparam int NUM_W = 64;
    localparam int DEN_W = DATA_W + 1;
    localparam int QB    = 35;
    localparam int DIV_LAT    = QB + 2;
    localparam int PIPE_DEPTH = QB + 6;

    localparam int SAT_W = 128;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7FFF_FFFF);
        lo = -SAT_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/cste_dline.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cste_dline
// Fixed-depth delay line that advances with the pipeline enable.
// ============================================================================
module cste_dline #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  wire logic             aclk,
    input  wire logic             ce,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (ce) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule
`default_nettype wire

// ----- hdl/cste_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cste_div
// Pipelined restoring divider, one quotient bit per stage. Magnitudes in,
// signed quotient out, truncated toward zero, magnitude clamped to QB bits.
// ============================================================================
module cste_div (
    input  wire logic                       aclk,
    input  wire logic                       ce,
    input  wire logic [cste_pkg::NUM_W-1:0] num_mag,
    input  wire logic [cste_pkg::DEN_W-1:0] den_mag,
    input  wire logic                       neg,
    output logic signed [cste_pkg::QB:0]    quot
);
    import cste_pkg::*;

    logic [DEN_W-1:0] rem_reg  [QB+1];
    logic [DEN_W-1:0] den_reg  [QB+1];
    logic [QB-1:0]    low_reg  [QB+1];
    logic [QB-1:0]    q_reg    [QB+1];
    logic             clamp_reg[QB+1];
    logic             neg_reg  [QB+1];
    logic signed [QB:0] quot_reg;

    logic clamp_in;
    assign clamp_in = (num_mag >> QB) >= NUM_W'(den_mag);

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]   <= clamp_in ? '0 : DEN_W'(num_mag >> QB);
            den_reg[0]   <= den_mag;
            low_reg[0]   <= num_mag[QB-1:0];
            q_reg[0]     <= '0;
            clamp_reg[0] <= clamp_in;
            neg_reg[0]   <= neg;
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_step
        logic [DEN_W:0] trial;
        logic           take;
        assign trial = {rem_reg[g-1], low_reg[g-1][QB-1]};
        assign take  = trial >= {1'b0, den_reg[g-1]};
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[g]   <= take ? DEN_W'(trial - {1'b0, den_reg[g-1]})
                                     : DEN_W'(trial);
                den_reg[g]   <= den_reg[g-1];
                low_reg[g]   <= {low_reg[g-1][QB-2:0], 1'b0};
                q_reg[g]     <= {q_reg[g-1][QB-2:0], take};
                clamp_reg[g] <= clamp_reg[g-1];
                neg_reg[g]   <= neg_reg[g-1];
            end
        end
    end

    logic [QB:0] qmag;
    assign qmag = clamp_reg[QB] ? {1'b0, {QB{1'b1}}} : {1'b0, q_reg[QB]};

    always_ff @(posedge aclk) begin
        if (ce) begin
            quot_reg <= neg_reg[QB] ? -$signed(qmag) : $signed(qmag);
        end
    end

    assign quot = quot_reg;
endmodule
`default_nettype wire

// ----- hdl/corotated_stress_energy_tangent_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// corotated_stress_energy_tangent_core
// Corotated linear elasticity in the principal frame: diagonal stress,
// energy density and off-diagonal tangent terms from three singular values.
// ============================================================================
// One element can enter per cycle; throughput is one element per cycle
// whenever the result side takes transfers. The pipeline depth is set by
// the three pipelined restoring dividers (35 quotient stages each) that
// form the tangent quotients, plus the multiply stages ahead of them. The
// whole pipeline holds while a result waits on m_tready. Write
// configuration only while no element is in flight.
// ============================================================================
module corotated_stress_energy_tangent_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [cste_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [cste_pkg::MOD_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // sigma_a, sigma_b, sigma_c
    input  wire logic [cste_pkg::IN_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // stress_a, stress_b, stress_c, energy, twist_ab, twist_ac, twist_bc,
    // shear_ab, shear_ac, shear_bc
    output logic [cste_pkg::OUT_W-1:0]          m_tdata
);
    import cste_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1 << FRAC_BITS);

    logic [MOD_W-1:0]   mu_reg;
    logic [MOD_W-1:0]   la_reg;
    logic [FLOOR_W-1:0] floor_reg;
    logic               twod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg    <= RESET_MU;
            la_reg    <= RESET_LAMBDA;
            floor_reg <= RESET_FLOOR;
            twod_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SHEAR_MODULUS:   mu_reg    <= cfg_wdata;
                REG_LAME_LAMBDA:     la_reg    <= cfg_wdata;
                REG_PANIC_FLOOR:     floor_reg <= cfg_wdata[FLOOR_W-1:0];
                REG_TWO_DIMENSIONAL: twod_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // stage 1: deviations, trace, clamped pair sums
    logic signed [DATA_W-1:0] sig[3];
    logic signed [DATA_W-1:0] sk[3];
    logic signed [DATA_W:0]   psum[3];
    logic [DATA_W:0]          pabs[3];
    logic [FLOOR_W-1:0]       floor_eff;

    logic signed [DATA_W:0]   e1_reg[3];
    logic signed [DATA_W+2:0] tr1_reg;
    logic signed [DATA_W-1:0] sk1_reg[3];
    logic [DEN_W-1:0]         dmag1_reg[3];
    logic                     dneg1_reg[3];
    logic                     twod1_reg;

    assign sig[0]    = $signed(s_tdata[DATA_W-1:0]);
    assign sig[1]    = $signed(s_tdata[2*DATA_W-1:DATA_W]);
    assign sig[2]    = twod_reg ? ONE : $signed(s_tdata[3*DATA_W-1:2*DATA_W]);
    assign sk[0]     = sig[2];
    assign sk[1]     = sig[1];
    assign sk[2]     = sig[0];
    assign psum[0]   = (DATA_W+1)'(sig[0]) + (DATA_W+1)'(sig[1]);
    assign psum[1]   = (DATA_W+1)'(sig[0]) + (DATA_W+1)'(sig[2]);
    assign psum[2]   = (DATA_W+1)'(sig[1]) + (DATA_W+1)'(sig[2]);
    assign floor_eff = (floor_reg == '0) ? FLOOR_W'(1) : floor_reg;

    for (genvar p = 0; p < 3; p++) begin : g_pair
        assign pabs[p] = psum[p][DATA_W] ? DEN_W'(-psum[p]) : DEN_W'(psum[p]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i]    <= (DATA_W+1)'(sig[i]) - (DATA_W+1)'(ONE);
                sk1_reg[i]   <= sk[i];
                dmag1_reg[i] <= (pabs[i] < DEN_W'(floor_eff)) ? DEN_W'(floor_eff) : pabs[i];
                dneg1_reg[i] <= psum[i][DATA_W];
            end
            tr1_reg   <= (DATA_W+3)'(sig[0]) + (DATA_W+3)'(sig[1]) + (DATA_W+3)'(sig[2])
                         - (DATA_W+3)'(3 * (1 << FRAC_BITS));
            twod1_reg <= twod_reg;
        end
    end

    // stage 2: products
    logic signed [DATA_W:0]   mu2s;
    logic signed [DATA_W:0]   las;
    logic [DATA_W:0]          emag[3];
    logic [DATA_W+2:0]        trmag;

    logic signed [67:0] pmu2_reg[3];
    logic signed [67:0] pla2_reg;
    logic [63:0]        sqp2_reg[3];
    logic [67:0]        t2_reg;
    logic signed [63:0] lask2_reg[3];
    logic [DEN_W-1:0]   dmag2_reg[3];
    logic               dneg2_reg[3];
    logic               twod2_reg;

    assign mu2s  = $signed({1'b0, mu_reg, 1'b0});
    assign las   = $signed({2'b0, la_reg});
    assign trmag = tr1_reg[DATA_W+2] ? (DATA_W+3)'(-tr1_reg) : (DATA_W+3)'(tr1_reg);
    for (genvar p = 0; p < 3; p++) begin : g_emag
        assign emag[p] = e1_reg[p][DATA_W] ? (DATA_W+1)'(-e1_reg[p])
                                           : (DATA_W+1)'(e1_reg[p]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                pmu2_reg[i]  <= mu2s * e1_reg[i];
                sqp2_reg[i]  <= emag[i] * emag[i];
                lask2_reg[i] <= las * sk1_reg[i];
                dmag2_reg[i] <= dmag1_reg[i];
                dneg2_reg[i] <= dneg1_reg[i];
            end
            pla2_reg  <= las * tr1_reg;
            t2_reg    <= trmag * trmag;
            twod2_reg <= twod1_reg;
        end
    end

    // stage 3: stress, numerators, first energy partials
    logic [33:0]        base34;
    logic signed [63:0] num[3];
    logic signed [67:0] ssum[3];

    logic [DATA_W-1:0]  stress3_reg[3];
    logic [63:0]        sq3_reg;
    logic [64:0]        latlo3_reg;
    logic [64:0]        lathi3_reg;
    logic [NUM_W-1:0]   nmag3_reg[3];
    logic [DEN_W-1:0]   dmag3_reg[3];
    logic               qneg3_reg[3];
    logic               twod3_reg;

    assign base34 = 34'(la_reg) + 34'(la_reg) + 34'(la_reg) + 34'({mu_reg, 1'b0});
    for (genvar p = 0; p < 3; p++) begin : g_num
        assign num[p]  = $signed(64'(base34) << FRAC_BITS) - lask2_reg[p];
        assign ssum[p] = pmu2_reg[p] + pla2_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                stress3_reg[i] <= sat32(SAT_W'(ssum[i] >>> FRAC_BITS));
                nmag3_reg[i]   <= num[i][63] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
                dmag3_reg[i]   <= dmag2_reg[i];
                qneg3_reg[i]   <= num[i][63] ^ dneg2_reg[i];
            end
            sq3_reg    <= sqp2_reg[0] + sqp2_reg[1] + sqp2_reg[2];
            latlo3_reg <= la_reg * t2_reg[33:0];
            lathi3_reg <= la_reg * t2_reg[67:34];
            twod3_reg  <= twod2_reg;
        end
    end

    // stage 4 and 5: energy
    logic [63:0]  mqlo4_reg;
    logic [63:0]  mqhi4_reg;
    logic [101:0] lat4_reg;
    logic [101:0] en5;
    logic [101:0] ensh5;
    logic [DATA_W-1:0] energy5_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            mqlo4_reg <= {mu_reg, 1'b0} * sq3_reg[31:0];
            mqhi4_reg <= {mu_reg, 1'b0} * sq3_reg[63:32];
            lat4_reg  <= 102'(latlo3_reg) + (102'(lathi3_reg) << 34);
        end
    end

    assign en5   = lat4_reg + 102'(mqlo4_reg) + (102'(mqhi4_reg) << 32);
    assign ensh5 = en5 >> (2 * FRAC_BITS + 1);

    always_ff @(posedge aclk) begin
        if (ce) begin
            energy5_reg <= (|ensh5[101:31]) ? 32'h7FFF_FFFF : ensh5[31:0];
        end
    end

    // tangent quotients
    logic signed [QB:0] quot[3];
    for (genvar p = 0; p < 3; p++) begin : g_div
        cste_div u_div (
            .aclk    (aclk),
            .ce      (ce),
            .num_mag (nmag3_reg[p]),
            .den_mag (dmag3_reg[p]),
            .neg     (qneg3_reg[p]),
            .quot    (quot[p])
        );
    end

    logic [3*DATA_W:0] side_in;
    logic [3*DATA_W:0] side_out;
    logic [DATA_W-1:0] energy_d;

    assign side_in = {twod3_reg, stress3_reg[2], stress3_reg[1], stress3_reg[0]};

    cste_dline #(
        .WIDTH (3 * DATA_W + 1),
        .DEPTH (DIV_LAT)
    ) u_side_dly (
        .aclk (aclk),
        .ce   (ce),
        .din  (side_in),
        .dout (side_out)
    );

    cste_dline #(
        .WIDTH (DATA_W),
        .DEPTH (DIV_LAT - 2)
    ) u_energy_dly (
        .aclk (aclk),
        .ce   (ce),
        .din  (energy5_reg),
        .dout (energy_d)
    );

    // final stage: tangent terms, 2D masking
    logic [DATA_W-1:0] twist[3];
    logic [DATA_W-1:0] shear[3];
    logic              twod_f;

    assign twod_f = side_out[3*DATA_W];
    for (genvar p = 0; p < 3; p++) begin : g_tan
        assign twist[p] = sat32(SAT_W'(quot[p]) - SAT_W'($signed({1'b0, la_reg})));
        assign shear[p] = sat32(SAT_W'($signed({1'b0, mu_reg, 1'b0}))
                                + SAT_W'($signed({1'b0, la_reg})) - SAT_W'(quot[p]));
    end

    logic [OUT_W-1:0] out_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= {twod_f ? '0 : shear[2],
                        twod_f ? '0 : shear[1],
                        shear[0],
                        twod_f ? '0 : twist[2],
                        twod_f ? '0 : twist[1],
                        twist[0],
                        energy_d,
                        twod_f ? '0 : side_out[3*DATA_W-1:2*DATA_W],
                        side_out[2*DATA_W-1:DATA_W],
                        side_out[DATA_W-1:0]};
        end
    end

    assign m_tdata = out_reg;
endmodule
`default_nettype wire

// ----- hdl/cste_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cste_checker
// Port-level checks of the core's stream channels, bound to the top level.
// ============================================================================
module cste_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [cste_pkg::OUT_W-1:0] m_tdata
);
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind corotated_stress_energy_tangent_core cste_checker u_cste_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/tb_corotated_stress_energy_tangent_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_corotated_stress_energy_tangent_core
// Self-checking regression for the corotated stress / energy / tangent core.
// Elements are streamed in under several material settings, in 3D and 2D.
// A scoreboard predicts every result field and compares the outputs in order.
// Both stream sides idle at random, and the result side holds off for a long
// stretch so that the pipeline backs up.
// ============================================================================
import cste_pkg::*;

typedef logic [OUT_W-1:0] stress_row_t;

class stress_scoreboard;
    longint      mu_q, lambda_q, floor_q;
    bit          planar;
    stress_row_t expected_rows[$];
    int          mismatches;
    int          checked;

    function new();
        mu_q = RESET_MU;
        lambda_q = RESET_LAMBDA;
        floor_q = RESET_FLOOR;
        planar = 1'b0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [MOD_W-1:0] val);
        case (idx)
            REG_SHEAR_MODULUS: mu_q = val;
            REG_LAME_LAMBDA: lambda_q = val;
            REG_PANIC_FLOOR: floor_q = val[FLOOR_W-1:0];
            REG_TWO_DIMENSIONAL: planar = val[0];
            default: ;
        endcase
    endfunction

    function logic [31:0] clip32(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -128'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function void pair_terms(longint si, longint sj, longint sk,
                             output logic [31:0] twist, output logic [31:0] shear);
        longint den, f, num, q;
        den = si + sj;
        f = (floor_q == 0) ? 1 : floor_q;
        if ((den < 0 ? -den : den) < f) den = (den < 0) ? -f : f;
        num = ((3 * lambda_q + 2 * mu_q) <<< FRAC_BITS) - lambda_q * sk;
        q = num / den;
        twist = clip32(q - lambda_q);
        shear = clip32(2 * mu_q + lambda_q - q);
    endfunction

    function stress_row_t element_result(logic signed [31:0] a, logic signed [31:0] b,
                                         logic signed [31:0] c);
        longint s[3];
        longint e[3];
        longint tr;
        logic [63:0] m;
        logic [63:0] sq;
        logic [127:0] tm, en;
        logic signed [127:0] acc, m2, la, ei, trs;
        logic [31:0] w[10];
        stress_row_t row;
        s[0] = a;
        s[1] = b;
        s[2] = planar ? (64'sd1 <<< FRAC_BITS) : longint'(c);
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            e[i] = s[i] - (64'sd1 <<< FRAC_BITS);
            m = (e[i] < 0) ? -e[i] : e[i];
            sq = sq + m * m;
        end
        tr = e[0] + e[1] + e[2];
        m2 = 2 * mu_q;
        la = lambda_q;
        trs = tr;
        for (int i = 0; i < 3; i++) begin
            ei = e[i];
            acc = m2 * ei + la * trs;
            w[i] = clip32(acc >>> FRAC_BITS);
        end
        tm = (tr < 0) ? -tr : tr;
        en = 128'(lambda_q) * (tm * tm) + 128'(2 * mu_q) * 128'(sq);
        w[3] = clip32($signed(en) >>> (2 * FRAC_BITS + 1));
        pair_terms(s[0], s[1], s[2], w[4], w[7]);
        pair_terms(s[0], s[2], s[1], w[5], w[8]);
        pair_terms(s[1], s[2], s[0], w[6], w[9]);
        if (planar) begin
            w[2] = 0; w[5] = 0; w[6] = 0; w[8] = 0; w[9] = 0;
        end
        for (int i = 0; i < 10; i++) row[32*i +: 32] = w[i];
        return row;
    endfunction

    function void note_element(logic [IN_W-1:0] data);
        expected_rows.push_back(element_result(data[31:0], data[63:32], data[95:64]));
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    task check_row(stress_row_t got);
        string names[10] = '{"stress_a", "stress_b", "stress_c", "energy", "twist_ab",
                             "twist_ac", "twist_bc", "shear_ab", "shear_ac", "shear_bc"};
        stress_row_t want;
        if (expected_rows.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_rows.pop_front();
        checked++;
        for (int i = 0; i < 10; i++)
            if (got[32*i +: 32] !== want[32*i +: 32])
                report($sformatf("result %0d %s got %h want %h", checked, names[i],
                                 got[32*i +: 32], want[32*i +: 32]));
    endtask
endclass

module tb_corotated_stress_energy_tangent_core;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd4;
    localparam int ONE = 1 << FRAC_BITS;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [MOD_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;   // sigma_a, sigma_b, sigma_c
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;        // stress_a..c, energy, twist_*, shear_*

    stress_scoreboard sb = new();
    bit  idling_on = 1'b1;
    int  hold_len = 0;
    int  sent = 0;

    corotated_stress_energy_tangent_core dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_row(m_tdata);
            if (hold_len > 0) begin
                hold_len <= hold_len - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idling_on && $urandom_range(99) < 7);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MOD_W-1:0] val);
        wait (sb.expected_rows.size() == 0);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic set_material(logic [30:0] mu, logic [30:0] la, logic [16:0] fl, bit pl);
        write_reg(REG_SHEAR_MODULUS, mu);
        write_reg(REG_LAME_LAMBDA, la);
        write_reg(REG_PANIC_FLOOR, MOD_W'(fl));
        write_reg(REG_TWO_DIMENSIONAL, MOD_W'(pl));
    endtask

    // hold s_tvalid high across back-to-back transfers; drop it only to idle
    task automatic send_element(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_element({c, b, a});
        sent++;
        if (idling_on && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_sigma();
        case ($urandom_range(9))
            0, 1, 2, 3: return ONE + $urandom_range(32768) - 16384;
            4, 5: return $urandom_range(1 << 19) - (1 << 18);
            6: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_elements(int n);
        logic [31:0] a, b, c;
        for (int i = 0; i < n; i++) begin
            a = pick_sigma();
            b = pick_sigma();
            c = pick_sigma();
            if ($urandom_range(9) == 0) b = -a + $urandom_range(8) - 4;
            if ($urandom_range(9) == 0) c = -a + $urandom_range(8) - 4;
            send_element(a, b, c);
        end
    endtask

    task automatic directed_elements();
        send_element(0, 0, 0);
        send_element(ONE, ONE, ONE);
        send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_element(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_element(32'h8000_0000, ONE, 32'h7FFF_FFFF);
        send_element(5, -5, 7);
        send_element(-3, 1, 2);
        send_element(ONE / 2, -ONE / 2, ONE * 2);
        send_element(32'hFFFF_FFFF, 0, 1);
        send_element(ONE * 3, ONE / 4, -ONE);
        send_element(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    endtask

    initial begin
        #20_000_000;
        $display("corotated_stress_energy_tangent_core regression: fail");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_elements();
        random_elements(60);
        s_tvalid <= 1'b0;

        set_material(31'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd65536, 1'b0);
        directed_elements();
        hold_len = 300;
        random_elements(80);
        s_tvalid <= 1'b0;
        wait (sb.expected_rows.size() == 0);

        set_material(0, 0, 17'd1, 1'b1);
        write_reg(REG_UNUSED, 31'h1234_5678);
        directed_elements();
        random_elements(60);
        s_tvalid <= 1'b0;

        set_material(31'($urandom), 31'($urandom_range(1 << 20)), 17'($urandom_range(1, 65536)),
                     1'b1);
        idling_on = 1'b0;
        random_elements(90);
        idling_on = 1'b1;
        s_tvalid <= 1'b0;

        set_material(31'($urandom_range(1 << 18)), 31'($urandom_range(1 << 18)), 17'd0, 1'b0);
        directed_elements();
        random_elements(90);
        s_tvalid <= 1'b0;

        set_material(31'($urandom), 31'($urandom), 17'($urandom_range(1, 65536)), 1'b0);
        random_elements(70);
        s_tvalid <= 1'b0;

        fork
            wait (sb.expected_rows.size() == 0);
            repeat (20000) @(posedge aclk);
        join_any
        disable fork;
        repeat (60) @(posedge aclk);
        if (sb.expected_rows.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_rows.size()));
        $display("covered %0d elements over six material settings (3D and 2D), %0d results checked",
                 sent, sb.checked);
        if (sb.mismatches == 0) begin
            $display("corotated_stress_energy_tangent_core regression: pass");
        end else begin
            $display("corotated_stress_energy_tangent_core regression: fail");
        end
        $finish;
    end
endmodule
